@@ src/button_short_long_press_detector_core_assert.svh @@
`ifndef BUTTON_SHORT_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_SHORT_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH

// checked outside reset
`define BSLPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BSLPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bslpd_pkg.sv @@
package bslpd_pkg;

  localparam int CNT_W = 16;
  localparam int BTN_W = 2;
  localparam int NUM_BTN = 4;
  localparam int EV_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd1;

  localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;
  localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PIN = 1'b1;

  localparam logic [BTN_W-1:0] BTN_BACK = 2'd0;
  localparam logic [BTN_W-1:0] BTN_UP = 2'd1;
  localparam logic [BTN_W-1:0] BTN_SELECT = 2'd2;
  localparam logic [BTN_W-1:0] BTN_DOWN = 2'd3;

  localparam logic [EV_W-1:0] EV_SHORT = 2'd0;
  localparam logic [EV_W-1:0] EV_LONG = 2'd1;
  localparam logic [EV_W-1:0] EV_RESET = 2'd2;

  typedef struct packed {
    logic tick;
    logic load;
    logic stop;
  } tmr_ctrl_t;

endpackage

@@ src/bslpd_timer.sv @@
module bslpd_timer #(
  parameter int CNT_W = bslpd_pkg::CNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bslpd_pkg::tmr_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    load_value,
  output logic                expire
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             run_r, run_nxt;

  assign expire = ctrl.tick && run_r && (count_r <= CNT_W'(1));

  always_comb begin
    count_nxt = count_r;
    run_nxt   = run_r;
    if (ctrl.load) begin
      count_nxt = load_value;
      run_nxt   = 1'b1;
    end else if (ctrl.stop || expire) begin
      count_nxt = '0;
      run_nxt   = 1'b0;
    end else if (ctrl.tick && run_r) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      run_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule

@@ src/button_short_long_press_detector_core.sv @@
// Short/long press detector for four active-low buttons. Each input transaction is
// either a timer tick or a pin change carrying the raw pin levels; a transaction
// produces at most one event (short press, long press or reset request). One
// transaction is accepted per clock while the result register is not stalled: it is
// captured in an input register, and a single pass of compare and counter-update
// logic then updates the debounce and hold countdowns and the tracked button and
// loads the result register. Configuration writes take effect on the next clock
// and are meant to be done while the block is idle.
module button_short_long_press_detector_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [bslpd_pkg::BTN_W-1:0]         in_button,
  input  logic [bslpd_pkg::NUM_BTN-1:0]       in_pin_levels,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bslpd_pkg::EV_W-1:0]          out_event_res,
  output logic [bslpd_pkg::BTN_W-1:0]         out_event_button,
  input  logic                                cfg_wr_en,
  input  logic [bslpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bslpd_pkg::CNT_W-1:0]         cfg_data
);

  logic [bslpd_pkg::CNT_W-1:0]   debounce_ticks_r;
  logic [bslpd_pkg::CNT_W-1:0]   long_press_ticks_r;

  logic                          in_vld_r;
  logic                          op_r;
  logic [bslpd_pkg::BTN_W-1:0]   button_r;
  logic [bslpd_pkg::NUM_BTN-1:0] levels_r;

  logic                          out_vld_r, out_vld_nxt;
  logic [bslpd_pkg::EV_W-1:0]    ev_res_r, ev_res_nxt;
  logic [bslpd_pkg::BTN_W-1:0]   ev_btn_r, ev_btn_nxt;

  logic [bslpd_pkg::BTN_W-1:0]   deb_btn_r, deb_btn_nxt;
  logic                          trk_vld_r, trk_vld_nxt;
  logic [bslpd_pkg::BTN_W-1:0]   trk_btn_r, trk_btn_nxt;

  bslpd_pkg::tmr_ctrl_t          deb_ctrl, hold_ctrl;
  logic                          deb_expire, hold_expire;

  logic                          step_fire;
  logic                          is_tick, is_pin, press, combo, deb_held, trk_held;
  logic                          emit;

  assign step_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || step_fire;

  assign is_tick  = step_fire && (op_r == bslpd_pkg::OP_TICK);
  assign is_pin   = step_fire && (op_r == bslpd_pkg::OP_PIN);
  assign press    = !levels_r[button_r];
  assign combo    = ((button_r == bslpd_pkg::BTN_UP) && !levels_r[bslpd_pkg::BTN_DOWN]) ||
                    ((button_r == bslpd_pkg::BTN_DOWN) && !levels_r[bslpd_pkg::BTN_UP]);
  assign deb_held = !levels_r[deb_btn_r];
  assign trk_held = !levels_r[trk_btn_r];

  always_comb begin
    deb_ctrl.tick  = is_tick;
    deb_ctrl.load  = is_pin && press && !combo;
    deb_ctrl.stop  = 1'b0;
    hold_ctrl.tick = is_tick && !deb_expire;
    hold_ctrl.load = deb_expire && deb_held;
    hold_ctrl.stop = (deb_expire && !deb_held) ||
                     (is_pin && !press && trk_vld_r && (trk_btn_r == button_r));
  end

  bslpd_timer #(.CNT_W(bslpd_pkg::CNT_W)) u_deb_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (deb_ctrl),
    .load_value (debounce_ticks_r),
    .expire     (deb_expire)
  );

  bslpd_timer #(.CNT_W(bslpd_pkg::CNT_W)) u_hold_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (hold_ctrl),
    .load_value (long_press_ticks_r),
    .expire     (hold_expire)
  );

  always_comb begin
    emit        = 1'b0;
    ev_res_nxt  = ev_res_r;
    ev_btn_nxt  = ev_btn_r;
    deb_btn_nxt = deb_btn_r;
    trk_vld_nxt = trk_vld_r;
    trk_btn_nxt = trk_btn_r;
    if (is_pin) begin
      if (press) begin
        if (combo) begin
          emit       = 1'b1;
          ev_res_nxt = bslpd_pkg::EV_RESET;
          ev_btn_nxt = button_r;
        end else begin
          deb_btn_nxt = button_r;
        end
      end else begin
        if (trk_vld_r && (trk_btn_r == button_r)) begin
          emit       = 1'b1;
          ev_res_nxt = bslpd_pkg::EV_SHORT;
          ev_btn_nxt = button_r;
        end
        trk_vld_nxt = 1'b0;
      end
    end else if (is_tick) begin
      if (deb_expire) begin
        if (deb_held) begin
          trk_vld_nxt = 1'b1;
          trk_btn_nxt = deb_btn_r;
        end
      end else if (hold_expire && trk_vld_r && trk_held) begin
        emit        = 1'b1;
        ev_res_nxt  = bslpd_pkg::EV_LONG;
        ev_btn_nxt  = trk_btn_r;
        trk_vld_nxt = 1'b0;
      end
    end
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= bslpd_pkg::DEBOUNCE_TICKS_RST;
      long_press_ticks_r <= bslpd_pkg::LONG_PRESS_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bslpd_pkg::REG_DEBOUNCE_TICKS: begin
          debounce_ticks_r <= cfg_data;
        end
        bslpd_pkg::REG_LONG_PRESS_TICKS: begin
          long_press_ticks_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      deb_btn_r <= '0;
      trk_vld_r <= 1'b0;
      trk_btn_r <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      deb_btn_r <= deb_btn_nxt;
      trk_vld_r <= trk_vld_nxt;
      trk_btn_r <= trk_btn_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r     <= in_op;
      button_r <= in_button;
      levels_r <= in_pin_levels;
    end
    ev_res_r <= ev_res_nxt;
    ev_btn_r <= ev_btn_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_event_res    = ev_res_r;
  assign out_event_button = ev_btn_r;

endmodule

@@ src/bslpd_checker.sv @@
`include "button_short_long_press_detector_core_assert.svh"

module bslpd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bslpd_pkg::EV_W-1:0]      out_event_res,
  input logic [bslpd_pkg::BTN_W-1:0]     out_event_button
);

  `BSLPD_ASSERT_ALWAYS(a_no_out_after_reset, !rst_n |=> !out_valid, "result valid right after reset")

  `BSLPD_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) && $stable(out_event_button),
    "stalled result changed")

  `BSLPD_ASSERT(a_res_code, out_valid |-> out_event_res <= bslpd_pkg::EV_RESET, "undefined event code")

  `BSLPD_ASSERT(a_reset_btn,
    out_valid && out_event_res == bslpd_pkg::EV_RESET |->
      out_event_button == bslpd_pkg::BTN_UP || out_event_button == bslpd_pkg::BTN_DOWN,
    "reset request not on up or down")

  // a new result needs a transaction held in the input register in the cycle before
  `BSLPD_ASSERT(a_no_out_from_idle,
    !$past(out_valid) && out_valid |-> $past(in_valid && in_ready, 2) || !$past(in_ready, 2),
    "result without a transaction in flight")

endmodule

bind button_short_long_press_detector_core bslpd_checker u_bslpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_res    (out_event_res),
  .out_event_button (out_event_button)
);

@@ test/tb_button_short_long_press_detector_core.sv @@
module tb_button_short_long_press_detector_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 350;
  localparam int RANDOM_PHASES = 10;
  localparam int MAX_WAIT = 17;

  typedef logic [bslpd_pkg::BTN_W-1:0] btn_t;
  typedef logic [bslpd_pkg::NUM_BTN-1:0] lvl_t;
  typedef logic [bslpd_pkg::CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [bslpd_pkg::EV_W-1:0] res;
    logic [bslpd_pkg::BTN_W-1:0] btn;
  } press_event_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_op;
  logic [bslpd_pkg::BTN_W-1:0] in_button;
  logic [bslpd_pkg::NUM_BTN-1:0] in_pin_levels;
  logic out_valid;
  logic out_ready;
  logic [bslpd_pkg::EV_W-1:0] out_event_res;
  logic [bslpd_pkg::BTN_W-1:0] out_event_button;
  logic cfg_wr_en;
  logic [bslpd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bslpd_pkg::CNT_W-1:0] cfg_data;

  // predictor copy of the configuration and the timers
  logic [bslpd_pkg::CNT_W-1:0] cfg_debounce = bslpd_pkg::DEBOUNCE_TICKS_RST;
  logic [bslpd_pkg::CNT_W-1:0] cfg_long_press = bslpd_pkg::LONG_PRESS_TICKS_RST;
  logic [bslpd_pkg::CNT_W-1:0] db_count = '0;
  logic db_run = 1'b0;
  logic [bslpd_pkg::BTN_W-1:0] db_btn = '0;
  logic [bslpd_pkg::CNT_W-1:0] hold_count = '0;
  logic hold_run = 1'b0;
  logic trk_valid = 1'b0;
  logic [bslpd_pkg::BTN_W-1:0] trk_btn = '0;

  press_event_t expected_events[$];
  bit failed = 1'b0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  int items_sent = 0;
  int cycles = 0;

  button_short_long_press_detector_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_button(in_button),
    .in_pin_levels(in_pin_levels),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_event_res(out_event_res),
    .out_event_button(out_event_button),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("button_short_long_press_detector_core: mismatch");
    $finish;
  end

  task automatic push_event(input logic [bslpd_pkg::EV_W-1:0] res,
                            input logic [bslpd_pkg::BTN_W-1:0] btn);
    press_event_t ev;
    ev.res = res;
    ev.btn = btn;
    expected_events.push_back(ev);
  endtask

  task automatic classify_transaction(input logic op, input logic [bslpd_pkg::BTN_W-1:0] btn,
                                      input logic [bslpd_pkg::NUM_BTN-1:0] lv);
    logic db_expired;
    db_expired = 1'b0;
    if (op == bslpd_pkg::OP_PIN) begin
      if (!lv[btn]) begin
        if ((btn == bslpd_pkg::BTN_UP && !lv[bslpd_pkg::BTN_DOWN]) ||
            (btn == bslpd_pkg::BTN_DOWN && !lv[bslpd_pkg::BTN_UP])) begin
          push_event(bslpd_pkg::EV_RESET, btn);
        end else begin
          db_count = cfg_debounce;
          db_run = 1'b1;
          db_btn = btn;
        end
      end else if (trk_valid && trk_btn == btn) begin
        hold_run = 1'b0;
        hold_count = '0;
        trk_valid = 1'b0;
        push_event(bslpd_pkg::EV_SHORT, btn);
      end else begin
        trk_valid = 1'b0;
      end
    end else begin
      if (db_run) begin
        if (db_count <= 1) begin
          db_count = '0;
          db_run = 1'b0;
          db_expired = 1'b1;
        end else begin
          db_count = db_count - 1'b1;
        end
      end
      if (db_expired) begin
        hold_run = 1'b0;
        hold_count = '0;
        if (!lv[db_btn]) begin
          trk_valid = 1'b1;
          trk_btn = db_btn;
          hold_count = cfg_long_press;
          hold_run = 1'b1;
        end
      end else if (hold_run) begin
        if (hold_count <= 1) begin
          hold_count = '0;
          hold_run = 1'b0;
          if (trk_valid && !lv[trk_btn]) begin
            trk_valid = 1'b0;
            push_event(bslpd_pkg::EV_LONG, trk_btn);
          end
        end else begin
          hold_count = hold_count - 1'b1;
        end
      end
    end
  endtask

  // result check first, then prediction for the transaction accepted at this edge
  always @(posedge clk) begin
    press_event_t exp_ev;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: expected no event, actual res=%0d button=%0d",
                   $time, out_event_res, out_event_button);
          failed = 1'b1;
        end else begin
          exp_ev = expected_events.pop_front();
          if (out_event_res !== exp_ev.res) begin
            $display("%0t: event_res expected %0d actual %0d",
                     $time, exp_ev.res, out_event_res);
            failed = 1'b1;
          end
          if (out_event_button !== exp_ev.btn) begin
            $display("%0t: event_button expected %0d actual %0d",
                     $time, exp_ev.btn, out_event_button);
            failed = 1'b1;
          end
        end
      end
      if (in_valid && in_ready)
        classify_transaction(in_op, in_button, in_pin_levels);
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(input logic op, input logic [bslpd_pkg::BTN_W-1:0] btn,
                           input logic [bslpd_pkg::NUM_BTN-1:0] lv);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_button <= btn;
    in_pin_levels <= lv;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bslpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bslpd_pkg::CNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == bslpd_pkg::REG_DEBOUNCE_TICKS)
      cfg_debounce = value;
    else
      cfg_long_press = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_values();
    tx_no_idle = 1'b1;
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_SELECT, 4'b1011);
    repeat (1050) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_BACK, 4'b1011);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_SELECT, 4'b1111);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_BACK, 4'b1110);
    repeat (60) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_DOWN, 4'b1110);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_BACK, 4'b1111);
    wait_idle();
    tx_no_idle = 1'b0;
  endtask

  task automatic test_directed();
    write_reg(bslpd_pkg::REG_DEBOUNCE_TICKS, 16'd2);
    write_reg(bslpd_pkg::REG_LONG_PRESS_TICKS, 16'd3);
    // short press of back, tick button field ignored
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_BACK, 4'b1110);
    send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_DOWN, 4'b1110);
    send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_UP, 4'b1110);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_BACK, 4'b1111);
    // long press of select, then its release gives nothing
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_SELECT, 4'b1011);
    repeat (5) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_BACK, 4'b1011);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_SELECT, 4'b1111);
    // up and down held together
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_UP, 4'b0000);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_DOWN, 4'b0101);
    // release of an untracked button, hold then runs out with nothing tracked
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_DOWN, 4'b0111);
    repeat (2) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_SELECT, 4'b0111);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_BACK, 4'b0111);
    repeat (3) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_SELECT, 4'b0111);
    // debounce runs out after the button let go
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_UP, 4'b1101);
    repeat (2) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_UP, 4'b1111);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    tx_no_idle = 1'b1;
    // zero counts act like one
    write_reg(bslpd_pkg::REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(bslpd_pkg::REG_LONG_PRESS_TICKS, 16'd0);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_BACK, 4'b1110);
    repeat (2) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_BACK, 4'b1110);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_BACK, 4'b1111);
    wait_idle();
    // full-scale debounce never runs out here
    write_reg(bslpd_pkg::REG_DEBOUNCE_TICKS, 16'hFFFF);
    write_reg(bslpd_pkg::REG_LONG_PRESS_TICKS, 16'd1);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_UP, 4'b1101);
    repeat (8) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_UP, 4'b1101);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_UP, 4'b1111);
    wait_idle();
    // full-scale hold ends in a short press
    write_reg(bslpd_pkg::REG_DEBOUNCE_TICKS, 16'd1);
    write_reg(bslpd_pkg::REG_LONG_PRESS_TICKS, 16'hFFFF);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_DOWN, 4'b0111);
    repeat (8) send_item(bslpd_pkg::OP_TICK, bslpd_pkg::BTN_SELECT, 4'b0111);
    send_item(bslpd_pkg::OP_PIN, bslpd_pkg::BTN_DOWN, 4'b1111);
    wait_idle();
    tx_no_idle = 1'b0;
  endtask

  task automatic test_random_sequences();
    int phase;
    int quota;
    int kind;
    int n;
    int k;
    logic [bslpd_pkg::BTN_W-1:0] idx;
    logic [bslpd_pkg::BTN_W-1:0] b;
    logic [bslpd_pkg::NUM_BTN-1:0] lv;
    quota = items_sent;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(bslpd_pkg::REG_DEBOUNCE_TICKS, cnt_t'($urandom_range(0, 6)));
      write_reg(bslpd_pkg::REG_LONG_PRESS_TICKS, cnt_t'($urandom_range(1, 12)));
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      quota += RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < quota) begin
        kind = $urandom_range(0, 19);
        b = btn_t'($urandom_range(0, 3));
        if (kind < 12) begin
          // press, hold for a while, release
          lv = 4'hF;
          if ($urandom_range(0, 3) == 0)
            lv = lvl_t'($urandom_range(0, 15));
          lv[b] = 1'b0;
          send_item(bslpd_pkg::OP_PIN, b, lv);
          n = $urandom_range(0, cfg_debounce + cfg_long_press + 3);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) begin
              idx = btn_t'($urandom_range(0, 3));
              lv[idx] = ~lv[idx];
            end
            send_item(bslpd_pkg::OP_TICK, btn_t'($urandom_range(0, 3)), lv);
          end
          lv[b] = 1'b1;
          send_item(bslpd_pkg::OP_PIN, b, lv);
        end else if (kind < 14) begin
          lv = lvl_t'($urandom_range(0, 15));
          lv[bslpd_pkg::BTN_UP] = 1'b0;
          lv[bslpd_pkg::BTN_DOWN] = 1'b0;
          send_item(bslpd_pkg::OP_PIN,
                    ($urandom_range(0, 1) == 1) ? bslpd_pkg::BTN_UP : bslpd_pkg::BTN_DOWN, lv);
        end else if (kind < 16) begin
          // contact bounce
          lv = 4'hF;
          lv[b] = 1'b0;
          send_item(bslpd_pkg::OP_PIN, b, lv);
          lv[b] = 1'b1;
          send_item(bslpd_pkg::OP_PIN, b, lv);
          lv[b] = 1'b0;
          send_item(bslpd_pkg::OP_PIN, b, lv);
          n = $urandom_range(0, cfg_debounce + 2);
          for (k = 0; k < n; k++)
            send_item(bslpd_pkg::OP_TICK, btn_t'($urandom_range(0, 3)), lv);
        end else begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++)
            send_item(1'($urandom_range(0, 1)), btn_t'($urandom_range(0, 3)),
                      lvl_t'($urandom_range(0, 15)));
        end
      end
      wait_idle();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = bslpd_pkg::OP_TICK;
    in_button = bslpd_pkg::BTN_BACK;
    in_pin_levels = 4'hF;
    cfg_wr_en = 1'b0;
    cfg_index = bslpd_pkg::REG_DEBOUNCE_TICKS;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed();
    test_config_extremes();
    test_random_sequences();
    wait_idle();
    if (!failed)
      $display("button_short_long_press_detector_core: match");
    else
      $display("button_short_long_press_detector_core: mismatch");
    $finish;
  end

endmodule

@@ button_short_long_press_detector_core.f @@
+incdir+src
src/bslpd_pkg.sv
src/bslpd_timer.sv
src/button_short_long_press_detector_core.sv
src/bslpd_checker.sv
test/tb_button_short_long_press_detector_core.sv
